// ----- sv/lkc_pkg.sv -----
// Shared constants and chain link type for the LRU key cache.
`timescale 1ns / 1ps
package lkc_pkg;

  localparam int DEF_ENTRIES  = 8;
  localparam int DEF_KEY_BITS = 16;

  localparam int PAGE_KEY_W = 16;
  localparam int CAP_W      = 4;
  localparam int OCC_W      = 4;

  localparam logic [CAP_W-1:0] CAP_RESET = 4'd4;

  // Passed from each cell to the next one down the recency row.
  typedef struct packed {
    logic seen;   // key matched in this cell or a more recent one
    logic valid;  // this cell holds a key
  } link_t;

endpackage

// ----- sv/lru_key_cache_top.sv -----
// LRU key cache top level: cell row, occupancy, capacity register and result register.
`timescale 1ns / 1ps
// The result of a transaction is registered and shows in the cycle after acceptance.
// Throughput: one reference per cycle; the compare-and-shift across the cell row finishes
// in the cycle of acceptance, and a held result stalls input only while out_stall is high.
// Reset (synchronous, rst_n low): all entries invalid, occupancy zero, capacity 4.
// The key storage itself is not cleared; no clearing pass is needed.
module lru_key_cache_top #(
  parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [lkc_pkg::CAP_W-1:0]       cfg_capacity,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [lkc_pkg::PAGE_KEY_W-1:0]  in_page_key,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_hit,
  output logic                            out_evicted,
  output logic [lkc_pkg::PAGE_KEY_W-1:0]  out_evicted_key,
  output logic [lkc_pkg::OCC_W-1:0]       out_occupancy
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > lkc_pkg::CAP_W) ? CNT_W : lkc_pkg::CAP_W;
  localparam int PKW   = lkc_pkg::PAGE_KEY_W;

  logic [lkc_pkg::CAP_W-1:0] cap_r;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic                      out_valid_r;
  logic                      out_hit_r;
  logic                      out_evicted_r;
  logic [PKW-1:0]            out_evicted_key_r;
  logic [lkc_pkg::OCC_W-1:0] out_occupancy_r;

  logic                      accept;
  logic                      hit;
  logic                      evict;
  logic                      grow;
  logic [CMP_W-1:0]          cap_raw;
  logic [CMP_W-1:0]          cap_eff;
  logic [CMP_W-1:0]          count_ext;
  logic [IDX_W-1:0]          miss_limit;
  logic [KEY_BITS-1:0]       key_s;
  logic [KEY_BITS-1:0]       ev_key;
  logic [PKW-1:0]            ev_key_out;
  logic [ENTRIES:0]          valid_ext;

  logic [KEY_BITS-1:0]       cell_key [ENTRIES];
  lkc_pkg::link_t            chain    [ENTRIES+1];

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;

  generate
    if (KEY_BITS >= PKW) begin : g_key_wide
      assign key_s      = KEY_BITS'(in_page_key);
      assign ev_key_out = ev_key[PKW-1:0];
    end else begin : g_key_narrow
      assign key_s      = in_page_key[KEY_BITS-1:0];
      assign ev_key_out = PKW'(ev_key);
    end
  endgenerate

  assign chain[0] = '{seen: 1'b0, valid: 1'b1};

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      lkc_cell #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS),
        .IDX      (gi)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (accept),
        .hit        (hit),
        .miss_limit (miss_limit),
        .key_ref    (key_s),
        .key_i      ((gi == 0) ? key_s : cell_key[(gi == 0) ? 0 : gi-1]),
        .link_i     (chain[gi]),
        .key_o      (cell_key[gi]),
        .link_o     (chain[gi+1])
      );
      assign valid_ext[gi] = chain[gi+1].valid;
    end
  endgenerate

  assign valid_ext[ENTRIES] = 1'b0;
  assign hit = chain[ENTRIES].seen;

  // Effective capacity: zero acts as one, saturates at the row length.
  assign cap_raw   = CMP_W'(cap_r);
  assign count_ext = CMP_W'(count_r);
  always_comb begin
    if (cap_raw == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_raw > CMP_W'(ENTRIES)) begin
      cap_eff = CMP_W'(ENTRIES);
    end else begin
      cap_eff = cap_raw;
    end
  end

  assign evict = !hit && (count_ext >= cap_eff) && (count_r != '0);
  assign grow  = !hit && !evict && (count_r < CNT_W'(ENTRIES));

  always_comb begin
    if (evict) begin
      miss_limit = IDX_W'(count_r - 1'b1);
    end else if (count_r >= CNT_W'(ENTRIES - 1)) begin
      miss_limit = IDX_W'(ENTRIES - 1);
    end else begin
      miss_limit = IDX_W'(count_r);
    end
  end

  // Least recent key sits in the last valid cell.
  always_comb begin
    ev_key = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (valid_ext[i] && !valid_ext[i+1]) begin
        ev_key = ev_key | cell_key[i];
      end
    end
    if (!evict) begin
      ev_key = '0;
    end
  end

  assign count_nxt = count_r + CNT_W'(grow);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= lkc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      cap_r <= cfg_capacity;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      if (accept) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_hit_r         <= hit;
      out_evicted_r     <= evict;
      out_evicted_key_r <= ev_key_out;
      out_occupancy_r   <= lkc_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;
  assign out_occupancy   = out_occupancy_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("occupancy above row length");

  a_valid_thermo: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_ext) == count_r)
    else $error("valid cells disagree with occupancy");

  a_valid_packed: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(valid_ext + 1'b1))
    else $error("valid cells not contiguous from most recent");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_evicted_r))
    else $error("hit and eviction in one transaction");

  a_evict_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !grow |=> count_r == $past(count_r))
    else $error("occupancy changed without a fill");

endmodule

// ----- sv/lkc_cell.sv -----
// One recency slot: holds a key, compares it with the reference, shifts from its neighbor.
`timescale 1ns / 1ps
module lkc_cell #(
  parameter int ENTRIES  = lkc_pkg::DEF_ENTRIES,
  parameter int KEY_BITS = lkc_pkg::DEF_KEY_BITS,
  parameter int IDX      = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         update,
  input  logic                         hit,
  input  logic [$clog2(ENTRIES)-1:0]   miss_limit,
  input  logic [KEY_BITS-1:0]          key_ref,
  input  logic [KEY_BITS-1:0]          key_i,
  input  lkc_pkg::link_t               link_i,
  output logic [KEY_BITS-1:0]          key_o,
  output lkc_pkg::link_t               link_o
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic [KEY_BITS-1:0] key_r;
  logic                valid_r;
  logic                match;
  logic                shift_en;

  assign match    = valid_r && (key_r == key_ref);
  assign shift_en = update && (hit ? !link_i.seen : (MY_IDX <= miss_limit));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (shift_en) begin
      valid_r <= link_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (shift_en) begin
      key_r <= key_i;
    end
  end

  assign key_o        = key_r;
  assign link_o.seen  = link_i.seen | match;
  assign link_o.valid = valid_r;

endmodule
